// ===== hdl/stc_pkg.sv =====
// shared types and constants for the cif token scanner
`timescale 1ns / 1ps

package stc_pkg;

    localparam int TEXT_W       = 8;
    localparam int OUT_W        = 32;
    localparam int POS_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_BARE   = 2'd0,
        KIND_QUOTED = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_NULL   = 2'd3
    } t_kind;

    localparam logic [TEXT_W-1:0] CH_NUL    = 8'h00;
    localparam logic [TEXT_W-1:0] CH_TAB    = 8'h09;
    localparam logic [TEXT_W-1:0] CH_LF     = 8'h0A;
    localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [TEXT_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [TEXT_W-1:0] CH_HASH   = 8'h23;
    localparam logic [TEXT_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [TEXT_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [TEXT_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [TEXT_W-1:0] CH_QMARK  = 8'h3F;

endpackage

// ===== hdl/stc_if.sv =====
// stream interfaces for text bytes in and tokens out
`timescale 1ns / 1ps

interface stc_in_if import stc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] token_start;
    logic [OUT_W-1:0] token_length;
    t_kind            token_kind;
    logic             closed_by_end;
    logic             offset_overflow;

    modport source (output valid, output token_start, output token_length,
                    output token_kind, output closed_by_end, output offset_overflow,
                    input ready);
    modport sink   (input valid, input token_start, input token_length,
                    input token_kind, input closed_by_end, input offset_overflow,
                    output ready);
endinterface

// ===== hdl/star_cif_tokenizer_unit.sv =====
// Streaming CIF tokenizer: one text byte per beat in, one token per beat out.
// Channels: i_in carries text_byte and end_of_text, one byte of the text per
// beat; end_of_text marks the last byte. o_out carries one beat per finished
// token: start offset, content length, kind (bare, quoted, text field, null),
// whether the end of text cut it, and the sticky offset saturation flag.
// Path: a byte accepted lands in the input register and is scanned from there
// into the output register, which shows its token on o_out. Throughput: one
// byte per cycle while o_out is not stalled, set by the single scan step
// between the input register and the output register; bytes that finish no
// token make no beat.
// Stall: while the output register holds a beat that is not taken, the scan
// step waits and i_in.ready drops once the input register is also full;
// nothing is lost or repeated.
// Reset: synchronous and active low; clears both registers' valid flags and
// the scanner state, so the next byte is at offset zero. After a byte with
// end_of_text the scanner also returns to its reset state.
`timescale 1ns / 1ps

module star_cif_tokenizer_unit
    import stc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stc_in_if.sink     i_in,
    stc_out_if.source  o_out
);

    localparam int EXT_W = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_QUOTED,
        MODE_QPEND,
        MODE_TEXT,
        MODE_TEXTLF
    } t_mode;

    // input register
    logic              r_in_valid;
    logic [TEXT_W-1:0] r_in_byte;
    logic              r_in_eot;

    // scanner state
    t_mode               r_mode,     n_mode;
    logic                r_qdouble,  n_qdouble;
    logic [POS_BITS-1:0] r_pos,      n_pos;
    logic [POS_BITS-1:0] r_start,    n_start;
    logic                r_prev_lf,  n_prev_lf;
    logic                r_prev_cr,  n_prev_cr;
    logic [TEXT_W-1:0]   r_first,    n_first;
    logic                r_ovf,      n_ovf;
    logic                r_drop_cr,  n_drop_cr;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_start;
    logic [OUT_W-1:0] r_out_len;
    t_kind            r_out_kind;
    logic             r_out_end;
    logic             r_out_ovf;

    logic                advance;
    logic                step;
    logic                in_accept;
    logic                sep;
    logic                lf;
    logic                is_null_ch;
    logic                at_max;
    logic [TEXT_W-1:0]   qch;
    logic [POS_BITS-1:0] p1;
    logic [POS_BITS-1:0] pm1;
    logic [POS_BITS-1:0] len_p;
    logic [POS_BITS-1:0] len_p1;
    logic [POS_BITS-1:0] len_pm1;
    logic [POS_BITS-1:0] len_text;
    logic                emit;
    logic [POS_BITS-1:0] e_len;
    logic [POS_BITS-1:0] e_start;
    t_kind               e_kind;
    logic                e_end;
    logic [EXT_W-1:0]    ext_len;
    logic [EXT_W-1:0]    ext_start;

    assign advance   = !r_out_valid || o_out.ready;
    assign step      = r_in_valid && advance;
    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign sep = (r_in_byte == CH_NUL) || (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB)
              || (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    assign lf  = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    assign is_null_ch = (r_in_byte == CH_QMARK) || (r_in_byte == CH_DOT);
    assign qch = r_qdouble ? CH_DQUOTE : CH_SQUOTE;

    assign at_max = (r_pos == POS_MAX);
    assign p1     = at_max ? POS_MAX : r_pos + POS_ONE;
    assign pm1    = (r_pos == '0) ? '0 : r_pos - POS_ONE;

    // clamped distances from the token start
    assign len_p    = (r_pos > r_start) ? r_pos - r_start : '0;
    assign len_p1   = (p1 > r_start) ? p1 - r_start : '0;
    assign len_pm1  = (pm1 > r_start) ? pm1 - r_start : '0;
    assign len_text = (r_drop_cr && len_pm1 != '0) ? len_pm1 - POS_ONE : len_pm1;

    always_comb begin
        n_mode    = r_mode;
        n_qdouble = r_qdouble;
        n_start   = r_start;
        n_first   = r_first;
        n_drop_cr = r_drop_cr;
        n_pos     = p1;
        n_ovf     = r_ovf || at_max;
        n_prev_lf = lf;
        n_prev_cr = (r_in_byte == CH_CR);
        emit      = 1'b0;
        e_len     = '0;
        e_start   = r_start;
        e_kind    = KIND_BARE;
        e_end     = 1'b0;

        case (r_mode)
            MODE_COMMENT: begin
                if (lf) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_WORD: begin
                if (sep || r_in_eot) begin
                    emit   = 1'b1;
                    e_len  = sep ? len_p : len_p1;
                    e_kind = (e_len == POS_ONE && (r_first == CH_QMARK || r_first == CH_DOT))
                           ? KIND_NULL : KIND_BARE;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                e_kind = KIND_QUOTED;
                if (r_in_byte == qch) begin
                    n_mode = MODE_QPEND;
                    emit   = r_in_eot;
                    e_len  = len_p;
                end else if (r_in_eot) begin
                    emit  = 1'b1;
                    e_len = len_p1;
                    e_end = 1'b1;
                end
            end
            MODE_QPEND: begin
                e_kind = KIND_QUOTED;
                if (sep) begin
                    emit   = 1'b1;
                    e_len  = len_pm1;
                    n_mode = MODE_IDLE;
                end else if (r_in_byte == qch) begin
                    emit  = r_in_eot;
                    e_len = len_p;
                end else begin
                    n_mode = MODE_QUOTED;
                    emit   = r_in_eot;
                    e_len  = len_p1;
                    e_end  = 1'b1;
                end
            end
            MODE_TEXT, MODE_TEXTLF: begin
                e_kind = KIND_TEXT;
                if (r_mode == MODE_TEXTLF && r_in_byte == CH_SEMI) begin
                    emit   = 1'b1;
                    e_len  = len_text;
                    n_mode = MODE_IDLE;
                end else begin
                    if (lf) begin
                        n_mode    = MODE_TEXTLF;
                        n_drop_cr = r_prev_cr && (r_pos > r_start);
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                    emit  = r_in_eot;
                    e_len = len_p1;
                    e_end = 1'b1;
                end
            end
            default: begin
                if (sep) begin
                    n_mode = MODE_IDLE;
                end else if (r_in_byte == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (r_in_byte == CH_DQUOTE || r_in_byte == CH_SQUOTE) begin
                    n_mode    = MODE_QUOTED;
                    n_qdouble = (r_in_byte == CH_DQUOTE);
                    n_start   = p1;
                    emit      = r_in_eot;
                    e_start   = p1;
                    e_kind    = KIND_QUOTED;
                    e_end     = 1'b1;
                end else if (r_in_byte == CH_SEMI && r_prev_lf) begin
                    n_mode  = MODE_TEXT;
                    n_start = p1;
                    emit    = r_in_eot;
                    e_start = p1;
                    e_kind  = KIND_TEXT;
                    e_end   = 1'b1;
                end else begin
                    n_mode  = MODE_WORD;
                    n_start = r_pos;
                    n_first = r_in_byte;
                    emit    = r_in_eot;
                    e_start = r_pos;
                    e_len   = POS_ONE;
                    e_kind  = is_null_ch ? KIND_NULL : KIND_BARE;
                end
            end
        endcase

        // the last byte of a text puts the scanner back to its reset state
        if (r_in_eot) begin
            n_mode    = MODE_IDLE;
            n_qdouble = 1'b0;
            n_pos     = '0;
            n_start   = '0;
            n_prev_lf = 1'b0;
            n_prev_cr = 1'b0;
            n_first   = '0;
            n_ovf     = 1'b0;
            n_drop_cr = 1'b0;
        end
    end

    assign ext_len   = EXT_W'(e_len);
    assign ext_start = EXT_W'(e_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_qdouble   <= 1'b0;
            r_pos       <= '0;
            r_start     <= '0;
            r_prev_lf   <= 1'b0;
            r_prev_cr   <= 1'b0;
            r_first     <= '0;
            r_ovf       <= 1'b0;
            r_drop_cr   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in.text_byte;
                r_in_eot   <= i_in.end_of_text;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (step) begin
                r_mode    <= n_mode;
                r_qdouble <= n_qdouble;
                r_pos     <= n_pos;
                r_start   <= n_start;
                r_prev_lf <= n_prev_lf;
                r_prev_cr <= n_prev_cr;
                r_first   <= n_first;
                r_ovf     <= n_ovf;
                r_drop_cr <= n_drop_cr;
            end

            if (advance) begin
                r_out_valid <= step && emit;
            end
            if (step && emit) begin
                r_out_start <= ext_start[OUT_W-1:0];
                r_out_len   <= ext_len[OUT_W-1:0];
                r_out_kind  <= e_kind;
                r_out_end   <= e_end;
                r_out_ovf   <= r_ovf || at_max;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.token_start     = r_out_start;
    assign o_out.token_length    = r_out_len;
    assign o_out.token_kind      = r_out_kind;
    assign o_out.closed_by_end   = r_out_end;
    assign o_out.offset_overflow = r_out_ovf;

endmodule

// ===== hdl/stc_checker.sv =====
// port checks for the cif token scanner and their binding
`timescale 1ns / 1ps

module stc_checker
    import stc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_len,
    input t_kind            i_out_kind,
    input logic             i_out_end
);

    // a held token beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("token beat dropped while stalled");

    // a held token keeps its kind
    a_kind_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_kind))
        else $error("token kind changed while stalled");

    // a null token is always one byte and never cut by the end of text
    a_null_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_NULL |-> i_out_len == OUT_W'(1) && !i_out_end)
        else $error("null token with bad length or end flag");

    // only quoted and text tokens can be cut short
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_end |-> i_out_kind == KIND_QUOTED || i_out_kind == KIND_TEXT)
        else $error("end flag on bare or null token");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token beat right after reset");

endmodule

bind star_cif_tokenizer_unit stc_checker u_stc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_len   (o_out.token_length),
    .i_out_kind  (o_out.token_kind),
    .i_out_end   (o_out.closed_by_end)
);
